@@ rtl/pse_pkg.sv @@
package pse_pkg;

  // Widths of the fields as they cross the ports.
  localparam int CNT_W = 7;   // row counts and view height
  localparam int COL_W = 10;  // column numbers
  localparam int ROW_W = 6;   // screen row of a span
  localparam int CLIP_W = 8;  // signed clip boundary

  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_FLOOR_MODE  = 1'b0,
    REG_VIEW_HEIGHT = 1'b1
  } reg_index_t;

  // One classified column, handed from front to back.
  typedef struct packed {
    logic [CNT_W-1:0] open_cnt;  // open rows before this column (clamped)
    logic [CNT_W-1:0] target;    // open rows wanted after this column
    logic [CNT_W-1:0] height;    // effective view height
    logic             floor;     // floor pass
    logic             last;      // flush after closing
    logic [COL_W-1:0] col;       // this column
    logic [COL_W-1:0] prev;      // column before it, wrapping
  } job_t;

endpackage

@@ rtl/plane_span_extractor_unit.sv @@
// Plane span extractor: turns a left-to-right stream of per-column clip rows
// into horizontal spans (row, first column, last column) for one plane.
//
// Channels:
//   in    : clip_row, last_column; transfer when in_valid && !in_stall.
//   out   : span_row, span_left, span_right, span_last; transfer when
//           out_valid && !out_stall. span_last marks the final span of a column.
//   cfg   : cfg_index/cfg_data, transfer when cfg_valid && cfg_ready (always
//           ready). Index 0 floor_mode, index 1 view_height.
// Timing: the front classifies a column in its transfer cycle and drops it in
//   a two-entry queue. Per column the back pops it, opens rows, closes rows
//   and, on the last column, flushes the rest, in that order. Spans leave one
//   per cycle while the output is not stalled; a span's start column is read
//   from the start-column memory into a read stage, then the output register.
//   Throughput is set by the back sequencer, which takes a new column only
//   once it is idle; the queue lets the front accept columns meanwhile.
// Reset: counters, queue and output go empty; floor_mode=0, view_height=64.
//   The start-column memory is not cleared.
// Stall: a stalled output holds and stops the back from issuing spans; the
//   queue can then fill and in_stall rises.
module plane_span_extractor_unit #(
  parameter int LINES   = 64,
  parameter int COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [pse_pkg::CNT_W-1:0]   cfg_data,
  // column input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pse_pkg::CLIP_W-1:0]  clip_row,
  input  logic                        last_column,
  // span output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pse_pkg::ROW_W-1:0]   span_row,
  output logic [pse_pkg::COL_W-1:0]   span_left,
  output logic [pse_pkg::COL_W-1:0]   span_right,
  output logic                        span_last
);
  import pse_pkg::*;

  logic       accept;
  logic       q_not_full;
  logic       q_not_empty;
  logic       q_pop;
  job_t       front_job;
  job_t       back_job;
  reg_index_t cfg_reg;

  assign cfg_ready = 1'b1;
  assign cfg_reg   = reg_index_t'(cfg_index);
  assign in_stall  = !q_not_full;
  assign accept    = in_valid && !in_stall;

  // front: config registers, open-row and column tracking, classification
  pse_front #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_reg),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .clip_row    (clip_row),
    .last_column (last_column),
    .job         (front_job)
  );

  // short queue decouples the front from the span sequencer
  pse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_job  (front_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (back_job)
  );

  // back: opens rows into the start-column memory, closes and flushes spans
  pse_back #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_not_empty),
    .job        (back_job),
    .job_pop    (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .span_row   (span_row),
    .span_left  (span_left),
    .span_right (span_right),
    .span_last  (span_last)
  );

endmodule

@@ rtl/pse_front.sv @@
module pse_front #(
  parameter int LINES   = 64,
  parameter int COLUMNS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  pse_pkg::reg_index_t          cfg_index,
  input  logic [pse_pkg::CNT_W-1:0]    cfg_data,
  input  logic                         accept,
  input  logic [pse_pkg::CLIP_W-1:0]   clip_row,
  input  logic                         last_column,
  output pse_pkg::job_t                job
);
  import pse_pkg::*;

  localparam int HW = $clog2(LINES + 1);
  localparam int CW = $clog2(COLUMNS);

  logic          floor_mode;
  logic [CNT_W-1:0] view_height;
  logic [HW-1:0] open_rows;
  logic [CW-1:0] column_index;

  logic [HW-1:0] h;
  logic [HW-1:0] open_clamped;
  logic signed [9:0] cs, hs, c;
  logic [HW-1:0] target;
  logic [CW-1:0] prev;

  always_comb begin
    if (view_height == '0) begin
      h = HW'(1);
    end else if (view_height > CNT_W'(LINES)) begin
      h = HW'(LINES);
    end else begin
      h = HW'(view_height);
    end
    open_clamped = (open_rows > h) ? h : open_rows;

    cs = 10'(signed'(clip_row));
    hs = signed'(10'(h));
    if (floor_mode) begin
      if (cs < -10'sd1) begin
        c = -10'sd1;
      end else if (cs > hs - 10'sd1) begin
        c = hs - 10'sd1;
      end else begin
        c = cs;
      end
      target = HW'(hs - 10'sd1 - c);
    end else begin
      if (cs < 10'sd0) begin
        c = 10'sd0;
      end else if (cs > hs) begin
        c = hs;
      end else begin
        c = cs;
      end
      target = HW'(c);
    end

    prev = (column_index == '0) ? CW'(COLUMNS - 1) : column_index - CW'(1);

    job.open_cnt = CNT_W'(open_clamped);
    job.target   = CNT_W'(target);
    job.height   = CNT_W'(h);
    job.floor    = floor_mode;
    job.last     = last_column;
    job.col      = COL_W'(column_index);
    job.prev     = COL_W'(prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_mode   <= 1'b0;
      view_height  <= CNT_W'(64);
      open_rows    <= '0;
      column_index <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FLOOR_MODE:  floor_mode  <= cfg_data[0];
          REG_VIEW_HEIGHT: view_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_column) begin
          open_rows    <= '0;
          column_index <= '0;
        end else begin
          open_rows    <= target;
          column_index <= (column_index == CW'(COLUMNS - 1)) ? '0
                                                             : column_index + CW'(1);
        end
      end
    end
  end

endmodule

@@ rtl/pse_queue.sv @@
module pse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pse_pkg::job_t push_job,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output pse_pkg::job_t pop_job
);
  import pse_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign not_full  = (count != (PW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/pse_back.sv @@
module pse_back #(
  parameter int LINES   = 64,
  parameter int COLUMNS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  pse_pkg::job_t               job,
  output logic                        job_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pse_pkg::ROW_W-1:0]   span_row,
  output logic [pse_pkg::COL_W-1:0]   span_left,
  output logic [pse_pkg::COL_W-1:0]   span_right,
  output logic                        span_last
);
  import pse_pkg::*;

  localparam int HW = $clog2(LINES + 1);
  localparam int LW = $clog2(LINES);
  localparam int CW = $clog2(COLUMNS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPEN,
    S_CLOSE,
    S_FLUSH
  } state_t;

  state_t        state;
  job_t          cur;
  logic [HW-1:0] cnt;

  // start column of each open row
  logic [CW-1:0] row_starts [LINES];
  logic [CW-1:0] rd_data;

  // read stage: row and right edge wait here while the start column is read
  logic          p_valid;
  logic [LW-1:0] p_row;
  logic [CW-1:0] p_right;
  logic          p_last;

  logic          adv;
  logic          issue;
  logic [LW-1:0] issue_row;
  logic [CW-1:0] issue_right;
  logic          issue_last;
  logic [HW-1:0] tgt;
  logic [HW-1:0] hgt;
  logic [HW-1:0] cnt_dec;
  logic [CW-1:0] x;
  logic [CW-1:0] x_prev;

  function automatic logic [LW-1:0] row_of(input logic [HW-1:0] k, input logic [HW-1:0] h,
                                           input logic fl);
    logic [HW-1:0] r;
    r = fl ? (h - HW'(1) - k) : k;
    return r[LW-1:0];
  endfunction

  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    tgt     = cur.target[HW-1:0];
    hgt     = cur.height[HW-1:0];
    x       = cur.col[CW-1:0];
    x_prev  = cur.prev[CW-1:0];
    cnt_dec = cnt - HW'(1);
    adv     = !out_valid || !out_stall;

    issue       = 1'b0;
    issue_row   = row_of(cnt_dec, hgt, cur.floor);
    issue_right = x_prev;
    issue_last  = 1'b0;
    case (state)
      S_CLOSE: begin
        issue      = adv && (cnt > tgt);
        issue_last = (cnt_dec == tgt) && !(cur.last && (tgt != '0));
      end
      S_FLUSH: begin
        issue       = adv && (cnt != '0);
        issue_right = x;
        issue_last  = (cnt == HW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_OPEN) && (cnt < tgt)) begin
      row_starts[row_of(cnt, hgt, cur.floor)] <= x;
    end
    if (issue) begin
      rd_data <= row_starts[issue_row];
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (issue) begin
      p_row   <= issue_row;
      p_right <= issue_right;
      p_last  <= issue_last;
    end
    if (adv) begin
      span_row   <= ROW_W'(p_row);
      span_left  <= COL_W'(rd_data);
      span_right <= COL_W'(p_right);
      span_last  <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= p_valid;
        p_valid   <= issue;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cnt   <= job.open_cnt[HW-1:0];
            state <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (cnt < tgt) begin
            cnt <= cnt + HW'(1);
          end else begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (cnt > tgt) begin
            if (issue) begin
              cnt <= cnt_dec;
            end
          end else begin
            state <= cur.last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (cnt != '0) begin
            if (issue) begin
              cnt <= cnt_dec;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  // Block geometry, kept at the defaults of the unit.
  localparam int LINES   = 64;
  localparam int COLUMNS = 1024;

  // After the last expected span the back end may still be busy on columns that
  // close nothing: two queued columns, each opening up to 64 rows.
  localparam int SETTLE_CYCLES  = 150;
  // Cycles in a row with no transfer on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_COLUMNS = 453;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic             last;
  } span_t;

  typedef enum {STEP_COLUMN, STEP_WRITE} step_kind_t;

  // One line of the directed table. Typed rows carry their expected outcome
  // (no span, or exactly one span); the rest go through the span predictor.
  typedef struct {
    step_kind_t                kind;
    reg_index_t                idx;
    logic [CNT_W-1:0]          data;
    logic signed [CLIP_W-1:0]  clip;
    logic                      last;
    bit                        typed;
    int                        typed_count;
    span_t                     typed_span;
  } step_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [0:0]                 cfg_index = REG_FLOOR_MODE;
  logic [CNT_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CLIP_W-1:0]          clip_row = '0;
  logic                       last_column = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ROW_W-1:0]           span_row;
  logic [COL_W-1:0]           span_left;
  logic [COL_W-1:0]           span_right;
  logic                       span_last;

  // Predictor state: its own copy of the registers, the open-row stack and
  // the start column of every row.
  bit                         pm_floor = 1'b0;
  logic [CNT_W-1:0]           pm_height = 7'd64;
  int                         open_cnt = 0;
  int                         col_idx = 0;
  logic [COL_W-1:0]           start_col [0:LINES-1];

  span_t                      column_spans[$];   // spans of the column just predicted
  span_t                      pending_spans[$];  // spans still owed by the unit

  bit                         quiet = 1'b0;      // no idling on either side
  int                         error_count = 0;
  int                         columns_sent = 0;
  int                         spans_seen = 0;
  int                         reg_writes = 0;
  int                         idle_cycles = 0;

  plane_span_extractor_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .clip_row    (clip_row),
    .last_column (last_column),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .span_row    (span_row),
    .span_left   (span_left),
    .span_right  (span_right),
    .span_last   (span_last)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Span predictor
  // ---------------------------------------------------------------------------

  // View height in use: the register saturated into 1..LINES.
  function automatic int eff_height();
    int h;
    h = int'(pm_height);
    if (h < 1) h = 1;
    if (h > LINES) h = LINES;
    return h;
  endfunction

  // Screen row of the k-th open row, counted from the edge rows grow from.
  function automatic int row_at(int k, int h);
    return (pm_floor ? (h - 1 - k) : k) % LINES;
  endfunction

  // Works out the spans that one column causes and advances the state.
  task automatic extract_spans(input logic signed [CLIP_W-1:0] clip_in, input logic last_in);
    int    h;
    int    x;
    int    prev;
    int    clip;
    int    target;
    int    r;
    span_t s;
    h = eff_height();
    x = col_idx % COLUMNS;
    prev = (x + COLUMNS - 1) % COLUMNS;   // column zero closes at the far right
    clip = int'(clip_in);
    column_spans.delete();
    // view height lowered in mid-frame: excess rows vanish without a span
    if (open_cnt > h) open_cnt = h;
    if (pm_floor) begin
      if (clip < -1) clip = -1;
      if (clip > h - 1) clip = h - 1;
      target = h - 1 - clip;
    end else begin
      if (clip < 0) clip = 0;
      if (clip > h) clip = h;
      target = clip;
    end
    while (open_cnt < target) begin
      start_col[row_at(open_cnt, h)] = COL_W'(x);
      open_cnt++;
    end
    // closing and flushing both unwind from the newest open row
    while (open_cnt > target) begin
      open_cnt--;
      r = row_at(open_cnt, h);
      s = {r[ROW_W-1:0], start_col[r], prev[COL_W-1:0], 1'b0};
      column_spans.push_back(s);
    end
    if (last_in) begin
      while (open_cnt > 0) begin
        open_cnt--;
        r = row_at(open_cnt, h);
        s = {r[ROW_W-1:0], start_col[r], x[COL_W-1:0], 1'b0};
        column_spans.push_back(s);
      end
      col_idx = 0;
    end else begin
      col_idx = (x + 1) % COLUMNS;
    end
    if (column_spans.size() > 0) column_spans[column_spans.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Nothing owed and the back end given time to drain columns that close nothing.
  task automatic wait_idle();
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, always from an idle unit.
  task automatic write_reg(input reg_index_t idx, input logic [CNT_W-1:0] data);
    in_valid <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FLOOR_MODE) pm_floor = data[0];
    else pm_height = data;
    reg_writes++;
  endtask

  // One column transfer. Expectations are queued at the transfer edge, before
  // any span of that column can leave the unit.
  task automatic send_column(input logic signed [CLIP_W-1:0] clip, input logic last,
                             input bit typed, input int typed_count, input span_t typed_span);
    in_valid    <= 1'b1;
    clip_row    <= clip;
    last_column <= last;
    do @(posedge clk); while (in_stall);
    extract_spans(clip, last);
    if (typed) begin
      if (typed_count == 1) pending_spans.push_back(typed_span);
    end else begin
      foreach (column_spans[i]) pending_spans.push_back(column_spans[i]);
    end
    columns_sent++;
    if (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Mostly small views, with both saturation ends and the full range mixed in.
  function automatic logic [CNT_W-1:0] pick_height();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd64;
      3: return 7'd1;
      4: return CNT_W'($urandom_range(65, 127));
      default: return CNT_W'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic step_t col_step(input logic signed [CLIP_W-1:0] clip, input logic last);
    step_t s;
    s = '{STEP_COLUMN, REG_FLOOR_MODE, '0, clip, last, 1'b0, 0, '0};
    return s;
  endfunction

  function automatic step_t typed_step(input logic signed [CLIP_W-1:0] clip, input logic last,
                                       input int cnt, input int row, input int left,
                                       input int right);
    step_t s;
    s = '{STEP_COLUMN, REG_FLOOR_MODE, '0, clip, last, 1'b1, cnt,
          {row[ROW_W-1:0], left[COL_W-1:0], right[COL_W-1:0], 1'b1}};
    return s;
  endfunction

  function automatic step_t write_step(input reg_index_t idx, input logic [CNT_W-1:0] data);
    step_t s;
    s = '{STEP_WRITE, idx, data, '0, 1'b0, 1'b0, 0, '0};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Span checker
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int seq, input int got, input int want);
    if (got != want)
      report_error($sformatf("span %0d: %s is %0d, expected %0d", seq, name, got, want));
  endtask

  always @(posedge clk) begin : span_check
    span_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        report_error($sformatf("span %0d: row %0d cols %0d..%0d with nothing expected",
                               spans_seen, span_row, span_left, span_right));
      end else begin
        want = pending_spans.pop_front();
        check_field("row", spans_seen, int'(span_row), int'(want.row));
        check_field("left", spans_seen, int'(span_left), int'(want.left));
        check_field("right", spans_seen, int'(span_right), int'(want.right));
        check_field("last", spans_seen, int'(span_last), int'(want.last));
      end
      spans_seen++;
    end
  end

  // Receiver back-pressure: about one cycle in five, none during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < 21);
  end

  // Watchdog on the longest run of cycles with no transfer anywhere.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR @%0t: no transfer for %0d cycles, %0d spans outstanding",
               $time, idle_cycles, pending_spans.size());
      $display("plane_span_extractor_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    step_t                    directed[$];
    logic signed [CLIP_W-1:0] clip;
    int                       frame_len;
    int                       random_cols;
    int                       h;
    int                       pick;
    bit                       first;

    foreach (start_col[i]) start_col[i] = '0;

    // Directed table, walked in order from reset (ceiling, view 64, column 0).
    directed = '{
      typed_step(-128, 1'b0, 0, 0, 0, 0),     // most negative clip, nothing opens
      typed_step(2, 1'b0, 0, 0, 0, 0),        // rows 0,1 open at column 1
      typed_step(1, 1'b0, 1, 1, 1, 1),        // row 1 closes at the column before
      typed_step(127, 1'b0, 0, 0, 0, 0),      // saturates to the full view
      col_step(64, 1'b1),                     // flush of all 64 rows
      write_step(REG_VIEW_HEIGHT, 7'd0),      // saturates to one row
      typed_step(5, 1'b0, 0, 0, 0, 0),
      typed_step(-1, 1'b1, 1, 0, 0, 0),       // close ends at column 0
      write_step(REG_VIEW_HEIGHT, 7'd127),    // saturates to 64
      write_step(REG_FLOOR_MODE, 1'b1),
      typed_step(-128, 1'b0, 0, 0, 0, 0),     // floor: every row opens
      col_step(127, 1'b0),                    // and every row closes
      typed_step(62, 1'b0, 0, 0, 0, 0),       // bottom row opens at column 2
      typed_step(63, 1'b1, 1, 63, 2, 2),
      write_step(REG_VIEW_HEIGHT, 7'd1),
      typed_step(-1, 1'b1, 1, 0, 0, 0),       // open and flush on one column
      write_step(REG_FLOOR_MODE, 1'b0),
      write_step(REG_VIEW_HEIGHT, 7'd64),
      typed_step(40, 1'b0, 0, 0, 0, 0),
      write_step(REG_VIEW_HEIGHT, 7'd10),     // lowered under 40 open rows
      col_step(3, 1'b0),                      // excess rows dropped silently
      col_step(10, 1'b1),
      write_step(REG_VIEW_HEIGHT, 7'd64)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_WRITE)
        write_reg(directed[i].idx, directed[i].data);
      else
        send_column(directed[i].clip, directed[i].last, directed[i].typed,
                    directed[i].typed_count, directed[i].typed_span);
    end

    // Random frames. Every frame ends on a last mark; the view is changed
    // between frames and now and then mid-frame where no unwritten start
    // column can be read (height in a ceiling pass, anything with no row open).
    random_cols = 0;
    first = 1'b1;
    while (random_cols < RANDOM_COLUMNS) begin
      if (first || $urandom_range(3) == 0) begin
        write_reg(REG_FLOOR_MODE, CNT_W'($urandom_range(1)));
        write_reg(REG_VIEW_HEIGHT, pick_height());
      end
      first = 1'b0;
      frame_len = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      clip = '0;
      for (int i = 0; i < frame_len; i++) begin
        quiet = (random_cols >= 150 && random_cols < 260);
        if (i > 0 && $urandom_range(24) == 0) begin
          if (open_cnt == 0) write_reg(REG_FLOOR_MODE, CNT_W'($urandom_range(1)));
          if (open_cnt == 0 || !pm_floor) write_reg(REG_VIEW_HEIGHT, pick_height());
        end
        h = eff_height();
        pick = $urandom_range(99);
        if (pick < 15) clip = CLIP_W'($urandom_range(255));          // anything, mostly saturated
        else if (pick >= 40) clip = CLIP_W'($urandom_range(h + 1) - 1);
        // otherwise the boundary holds and the column emits nothing, bar the flush of a last column
        send_column(clip, (i == frame_len - 1), 1'b0, 0, '0);
        random_cols++;
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    wait_idle();

    $display("ran %0d columns and checked %0d spans across %0d register writes",
             columns_sent, spans_seen, reg_writes);
    $display("floor and ceiling passes, view heights 1..64 incl. saturation, mid-frame changes");
    if (error_count == 0 && pending_spans.size() == 0)
      $display("plane_span_extractor_unit: match");
    else
      $display("plane_span_extractor_unit: mismatch");
    $finish;
  end

endmodule
